### rtl/core/precharge_mosfet_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// Precharge MOSFET sequencer assertion macros
// Shared concurrent assertion forms used by the sequencer checker.
// ----------------------------------------------------------------------------
`ifndef PRECHARGE_MOSFET_SEQUENCER_TOP_MACROS_SVH
`define PRECHARGE_MOSFET_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pms_pkg.sv
// ----------------------------------------------------------------------------
// Precharge MOSFET sequencer package
// Types, codes and reset constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

  // Time added to a running phase on every tick.
  localparam logic [16:0] TICK_MS = 17'd10;

  // Request types.
  localparam logic [1:0] REQ_SET  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_INIT = 2'd2;

  // Target states.
  localparam logic [2:0] TGT_OFF        = 3'd0;
  localparam logic [2:0] TGT_ON         = 3'd1;
  localparam logic [2:0] TGT_DISCHARGE  = 3'd2;
  localparam logic [2:0] TGT_FIRST_BAD  = 3'd4;
  localparam logic [2:0] TGT_RETRY_FAIL = 3'd5;
  localparam logic [2:0] TGT_UNINIT     = 3'd7;

  // Result status codes.
  localparam logic [2:0] RS_SUCCESS   = 3'd0;
  localparam logic [2:0] RS_FORBIDDEN = 3'd1;
  localparam logic [2:0] RS_INVALID   = 3'd2;
  localparam logic [2:0] RS_UNINIT    = 3'd3;
  localparam logic [2:0] RS_TICK      = 3'd4;

  // Event codes beyond the plain state codes.
  localparam logic [2:0] EV_OFF        = 3'd0;
  localparam logic [2:0] EV_RETRY_FAIL = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PRECHARGE_TIME = 2'd0;
  localparam logic [1:0] CFG_RETRY_OFF_TIME = 2'd1;
  localparam logic [1:0] CFG_VOLTAGE_THRESH = 2'd2;
  localparam logic [1:0] CFG_MAX_RETRIES    = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] RST_PRECHARGE_TIME = 16'd500;
  localparam logic [15:0] RST_RETRY_OFF_TIME = 16'd1000;
  localparam logic [15:0] RST_VOLTAGE_THRESH = 16'd30000;
  localparam logic [7:0]  RST_MAX_RETRIES    = 8'd3;

  // Sequencer control phase.
  typedef enum logic [2:0] {
    PH_UNINIT    = 3'd0,
    PH_OFF       = 3'd1,
    PH_ON        = 3'd2,
    PH_PRE       = 3'd3,
    PH_RETRY_ON  = 3'd5,
    PH_RETRY_OFF = 3'd6,
    PH_FAIL      = 3'd7
  } phase_t;

  typedef struct packed {
    logic [15:0] precharge_time_ms;
    logic [15:0] retry_off_time_ms;
    logic [15:0] voltage_threshold_mv;
    logic [7:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  requested_state;
    logic        afe_protection;
    logic [1:0]  afe_switch_state;
    logic [15:0] pack_voltage_mv;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       drive_write;
    logic [1:0] drive_value;
    logic       precharge_pin;
    logic       event_valid;
    logic [2:0] event_code;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/pms_cfg.sv
// ----------------------------------------------------------------------------
// Precharge MOSFET sequencer configuration registers
// Holds the timing, threshold and retry limit written through the write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pms_cfg
  import pms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  // Register file, one write per cycle, reset to the documented defaults.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.precharge_time_ms    <= RST_PRECHARGE_TIME;
      cfg.retry_off_time_ms    <= RST_RETRY_OFF_TIME;
      cfg.voltage_threshold_mv <= RST_VOLTAGE_THRESH;
      cfg.max_retries          <= RST_MAX_RETRIES;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRECHARGE_TIME: cfg.precharge_time_ms    <= cfg_data;
        CFG_RETRY_OFF_TIME: cfg.retry_off_time_ms    <= cfg_data;
        CFG_VOLTAGE_THRESH: cfg.voltage_threshold_mv <= cfg_data;
        CFG_MAX_RETRIES:    cfg.max_retries          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/pms_in_stage.sv
// ----------------------------------------------------------------------------
// Precharge MOSFET sequencer input register
// Captures one request transaction and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pms_in_stage
  import pms_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire item_t in_item,
  input  wire logic  down_ready,
  output logic       advance,
  output item_t      item
);

  logic held;

  // The held item moves on whenever the result register can take it.
  assign advance  = held && down_ready;
  assign in_stall = held && !down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/core/pms_step.sv
// ----------------------------------------------------------------------------
// Precharge MOSFET sequencer step logic
// Sequencer state and the single-pass update for one request or tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pms_step
  import pms_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  advance,
  input  wire item_t item,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [2:0]  target, target_next;
  logic [15:0] phase_time, phase_time_next;
  logic [7:0]  retry_count, retry_count_next;
  logic        precharge_level, precharge_level_next;

  // State registers, updated only when an item is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_UNINIT;
      target          <= TGT_UNINIT;
      phase_time      <= '0;
      retry_count     <= '0;
      precharge_level <= 1'b0;
    end else if (advance) begin
      phase           <= phase_next;
      target          <= target_next;
      phase_time      <= phase_time_next;
      retry_count     <= retry_count_next;
      precharge_level <= precharge_level_next;
    end
  end

  // Next state and result for the held item.
  always_comb begin
    logic [2:0]  tgt;
    logic [16:0] time_sum;
    logic [15:0] time_inc;
    logic [7:0]  retry_inc;
    logic        drv_en;
    logic [2:0]  drv_state;

    phase_next           = phase;
    target_next          = target;
    phase_time_next      = phase_time;
    retry_count_next     = retry_count;
    precharge_level_next = precharge_level;
    res                  = '0;
    res.status           = RS_TICK;
    drv_en               = 1'b0;
    drv_state            = target;
    tgt                  = target;

    // Saturating phase timer and retry counter increments.
    time_sum  = {1'b0, phase_time} + TICK_MS;
    time_inc  = time_sum[16] ? 16'hFFFF : time_sum[15:0];
    retry_inc = (retry_count == 8'hFF) ? retry_count : retry_count + 8'd1;

    case (item.req_type)
      REQ_SET, REQ_INIT: begin
        // Init loads the target from the front end if it was never set.
        if (item.req_type == REQ_INIT && target == TGT_UNINIT) begin
          tgt = {1'b0, item.afe_switch_state};
        end
        target_next = tgt;
        if (item.afe_protection) begin
          target_next = TGT_OFF;
          res.status  = RS_FORBIDDEN;
        end else if (item.requested_state >= TGT_FIRST_BAD) begin
          res.status = RS_INVALID;
        end else if (tgt == TGT_UNINIT) begin
          res.status = RS_UNINIT;
        end else if (tgt == item.requested_state) begin
          res.status = RS_SUCCESS;
        end else begin
          res.status  = RS_SUCCESS;
          target_next = item.requested_state;
          if ((phase inside {PH_UNINIT, PH_OFF}) &&
              (item.requested_state inside {TGT_ON, TGT_DISCHARGE}) &&
              (cfg.precharge_time_ms != 16'd0)) begin
            // Turning on from off starts precharge instead of driving.
            phase_next           = PH_PRE;
            phase_time_next      = '0;
            retry_count_next     = '0;
            precharge_level_next = 1'b1;
          end else begin
            drv_en    = 1'b1;
            drv_state = item.requested_state;
          end
        end
      end

      REQ_TICK: begin
        case (phase)
          PH_PRE, PH_RETRY_ON: begin
            phase_time_next = time_inc;
            if (time_inc >= cfg.precharge_time_ms) begin
              phase_time_next      = '0;
              precharge_level_next = 1'b0;
              if (item.pack_voltage_mv >= cfg.voltage_threshold_mv) begin
                drv_en    = 1'b1;
                drv_state = target;
              end else begin
                // Voltage check failed: pause, count the try, latch on too many.
                phase_next       = PH_RETRY_OFF;
                retry_count_next = retry_inc;
                if (retry_inc > cfg.max_retries) begin
                  target_next     = TGT_RETRY_FAIL;
                  phase_next      = PH_FAIL;
                  res.event_valid = 1'b1;
                  res.event_code  = EV_RETRY_FAIL;
                end
              end
            end
          end
          PH_RETRY_OFF: begin
            phase_time_next = time_inc;
            if (time_inc >= cfg.retry_off_time_ms) begin
              phase_time_next      = '0;
              phase_next           = PH_RETRY_ON;
              precharge_level_next = 1'b1;
            end
          end
          default: ;
        endcase
      end

      default: ;
    endcase

    // Switch drive; a target outside the drivable states does nothing.
    if (drv_en && drv_state < TGT_FIRST_BAD) begin
      res.drive_write      = 1'b1;
      res.drive_value      = drv_state[1:0];
      precharge_level_next = 1'b0;
      phase_next           = (drv_state == TGT_OFF) ? PH_OFF : PH_ON;
      res.event_valid      = 1'b1;
      res.event_code       = (drv_state == TGT_OFF) ? EV_OFF : drv_state;
    end

    res.precharge_pin = precharge_level_next;
  end

endmodule

`default_nettype wire

### rtl/core/pms_out_stage.sv
// ----------------------------------------------------------------------------
// Precharge MOSFET sequencer result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pms_out_stage
  import pms_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         ready,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      res
);

  // The register can load when empty or when its content leaves this cycle.
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

`default_nettype wire

### rtl/core/precharge_mosfet_sequencer_top.sv
// ----------------------------------------------------------------------------
// Precharge MOSFET sequencer top level
// Sequences battery pack switches with a timed, retried precharge phase.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Contents
//   in       input      in_valid / in_stall    request, init or 10 ms tick
//   out      output     out_valid / out_stall  status, drive write, pin, event
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// One transaction is accepted per cycle while the output does not stall; each
// gives one result through the input register, then the result register.
// The state update is one pass of compare and add logic between the registers.
// Reset is synchronous and active high; it restores the default configuration.
// A stall on the output holds the result and, once the input register is
// full, stalls the input in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module precharge_mosfet_sequencer_top
  import pms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [2:0]  requested_state,
  input  wire logic        afe_protection,
  input  wire logic [1:0]  afe_switch_state,
  input  wire logic [15:0] pack_voltage_mv,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic             drive_write,
  output logic [1:0]       drive_value,
  output logic             precharge_pin,
  output logic             event_valid,
  output logic [2:0]       event_code,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  result_t step_res;
  result_t res;
  logic    ready;
  logic    advance;

  assign in_item = '{req_type:         req_type,
                     requested_state:  requested_state,
                     afe_protection:   afe_protection,
                     afe_switch_state: afe_switch_state,
                     pack_voltage_mv:  pack_voltage_mv};

  pms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pms_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .down_ready (ready),
    .advance    (advance),
    .item       (item)
  );

  pms_step u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (item),
    .res     (step_res)
  );

  pms_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (step_res),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Result fields onto their ports.
  assign status        = res.status;
  assign drive_write   = res.drive_write;
  assign drive_value   = res.drive_value;
  assign precharge_pin = res.precharge_pin;
  assign event_valid   = res.event_valid;
  assign event_code    = res.event_code;

endmodule

`default_nettype wire

### rtl/core/pms_checker.sv
// ----------------------------------------------------------------------------
// Precharge MOSFET sequencer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "precharge_mosfet_sequencer_top_macros.svh"

module pms_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] status,
  input wire logic       drive_write,
  input wire logic [1:0] drive_value,
  input wire logic       precharge_pin,
  input wire logic       event_valid,
  input wire logic [2:0] event_code
);

  // A stalled result stays and holds its contents.
  `PMS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(drive_write) && $stable(drive_value) && $stable(precharge_pin) && $stable(event_valid) && $stable(event_code), "stalled result changed")

  // A switch drive always raises an event and leaves the precharge path off.
  `PMS_ASSERT_SAME(a_drive_event, clk, rst, out_valid && drive_write, event_valid && !precharge_pin, "drive without event or with precharge on")

  // No drive value is shown without a drive write.
  `PMS_ASSERT_SAME(a_drive_zero, clk, rst, out_valid && !drive_write, drive_value == 2'd0, "drive value without write")

  // No event code is shown without an event.
  `PMS_ASSERT_SAME(a_event_zero, clk, rst, out_valid && !event_valid, event_code == 3'd0, "event code without event")

endmodule

bind precharge_mosfet_sequencer_top pms_checker u_pms_checker (.*);

`default_nettype wire

### verif/precharge_mosfet_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Precharge MOSFET sequencer testbench
// Drives set-state, init and tick transactions through the valid/stall
// channels, predicts every result in a local model of the sequencer and
// compares each result field by field. A directed table covers reset
// behavior, error codes and the precharge, retry and failure-latch paths;
// random phases under several register settings follow.
// ----------------------------------------------------------------------------

module precharge_mosfet_sequencer_top_tb;
  import pms_pkg::*;

  // Codes that the package does not name.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] TGT_CHARGE = 3'd3;

  // One row of the directed table: a register setting or a repeated transaction.
  typedef struct {
    bit          is_settings;
    cfg_t        settings;
    item_t       req;
    int unsigned reps;
    bit          checked;
    result_t     res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = REQ_SET;
  logic [2:0]  requested_state = TGT_OFF;
  logic        afe_protection = 1'b0;
  logic [1:0]  afe_switch_state = 2'd0;
  logic [15:0] pack_voltage_mv = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        drive_write;
  logic [1:0]  drive_value;
  logic        precharge_pin;
  logic        event_valid;
  logic [2:0]  event_code;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_PRECHARGE_TIME;
  logic [15:0] cfg_data = 16'd0;

  // Model of the sequencer state and its registers.
  cfg_t        cfg_model;
  logic [2:0]  tgt_model;
  phase_t      phase_model;
  logic [15:0] elapsed_ms;
  logic [7:0]  retry_tally;
  logic        pin_model;

  result_t     results_due[$];
  int          error_count = 0;
  bit          idling_allowed = 1'b1;
  int unsigned sink_hold_left = 0;

  precharge_mosfet_sequencer_top uut (.*);

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sequencer model
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] add_tick(input logic [15:0] t);
    logic [16:0] sum;
    sum = {1'b0, t} + TICK_MS;
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  // Writes the switches with a drivable state and raises the matching event.
  function automatic void drive_switches(input logic [2:0] s, inout result_t r);
    if (s < TGT_FIRST_BAD) begin
      r.drive_write = 1'b1;
      r.drive_value = s[1:0];
      r.event_valid = 1'b1;
      r.event_code  = s;
      pin_model     = 1'b0;
      phase_model   = (s == TGT_OFF) ? PH_OFF : PH_ON;
    end
  endfunction

  function automatic logic [2:0] handle_request(input logic [2:0] req, input logic prot,
                                                inout result_t r);
    if (prot) begin
      tgt_model = TGT_OFF;
      return RS_FORBIDDEN;
    end
    if (req >= TGT_FIRST_BAD) return RS_INVALID;
    if (tgt_model == TGT_UNINIT) return RS_UNINIT;
    if (tgt_model == req) return RS_SUCCESS;
    tgt_model = req;
    // Turning on from off goes through precharge unless its time is zero.
    if ((phase_model == PH_UNINIT || phase_model == PH_OFF) &&
        (req == TGT_ON || req == TGT_DISCHARGE) && cfg_model.precharge_time_ms != 16'd0) begin
      phase_model = PH_PRE;
      elapsed_ms  = 16'd0;
      retry_tally = 8'd0;
      pin_model   = 1'b1;
      return RS_SUCCESS;
    end
    drive_switches(req, r);
    return RS_SUCCESS;
  endfunction

  function automatic result_t predict_sequencer_result(input item_t it);
    result_t    r;
    logic [2:0] st;
    r = '0;
    r.status = RS_TICK;
    case (it.req_type)
      REQ_SET: begin
        st = handle_request(it.requested_state, it.afe_protection, r);
        r.status = st;
      end
      REQ_INIT: begin
        if (tgt_model == TGT_UNINIT) tgt_model = {1'b0, it.afe_switch_state};
        st = handle_request(it.requested_state, it.afe_protection, r);
        r.status = st;
      end
      REQ_TICK: begin
        if (phase_model == PH_PRE || phase_model == PH_RETRY_ON) begin
          elapsed_ms = add_tick(elapsed_ms);
          if (elapsed_ms >= cfg_model.precharge_time_ms) begin
            elapsed_ms = 16'd0;
            if (it.pack_voltage_mv >= cfg_model.voltage_threshold_mv) begin
              drive_switches(tgt_model, r);
              pin_model = 1'b0;
            end else begin
              // Failed voltage check: pause, count it and latch after too many.
              phase_model = PH_RETRY_OFF;
              pin_model   = 1'b0;
              if (retry_tally != 8'hFF) retry_tally = retry_tally + 8'd1;
              if (retry_tally > cfg_model.max_retries) begin
                tgt_model     = TGT_RETRY_FAIL;
                phase_model   = PH_FAIL;
                r.event_valid = 1'b1;
                r.event_code  = EV_RETRY_FAIL;
              end
            end
          end
        end else if (phase_model == PH_RETRY_OFF) begin
          elapsed_ms = add_tick(elapsed_ms);
          if (elapsed_ms >= cfg_model.retry_off_time_ms) begin
            elapsed_ms  = 16'd0;
            phase_model = PH_RETRY_ON;
            pin_model   = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.precharge_pin = pin_model;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Table builders
  // ---------------------------------------------------------------------------

  function automatic item_t make_item(input logic [1:0] kind, input logic [2:0] req,
                                      input logic prot, input logic [1:0] afe,
                                      input logic [15:0] pv);
    item_t it;
    it.req_type         = kind;
    it.requested_state  = req;
    it.afe_protection   = prot;
    it.afe_switch_state = afe;
    it.pack_voltage_mv  = pv;
    return it;
  endfunction

  function automatic result_t result_of(input logic [2:0] st, input logic dw,
                                        input logic [1:0] dv, input logic pin,
                                        input logic ev, input logic [2:0] code);
    result_t r;
    r.status        = st;
    r.drive_write   = dw;
    r.drive_value   = dv;
    r.precharge_pin = pin;
    r.event_valid   = ev;
    r.event_code    = code;
    return r;
  endfunction

  function automatic cfg_t settings_of(input logic [15:0] pre_ms, input logic [15:0] off_ms,
                                       input logic [15:0] thresh, input logic [7:0] retries);
    cfg_t c;
    c.precharge_time_ms    = pre_ms;
    c.retry_off_time_ms    = off_ms;
    c.voltage_threshold_mv = thresh;
    c.max_retries          = retries;
    return c;
  endfunction

  function automatic stim_row_t item_row(input item_t it, input int unsigned reps);
    stim_row_t row;
    row = '{default: '0};
    row.req  = it;
    row.reps = reps;
    return row;
  endfunction

  function automatic stim_row_t checked_row(input item_t it, input result_t res);
    stim_row_t row;
    row = item_row(it, 1);
    row.checked = 1'b1;
    row.res     = res;
    return row;
  endfunction

  function automatic stim_row_t settings_row(input cfg_t c);
    stim_row_t row;
    row = '{default: '0};
    row.is_settings = 1'b1;
    row.settings    = c;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Sends one transaction, records its expected result and maybe idles after it.
  task automatic apply_item(input item_t it, input bit checked, input result_t typed_res);
    result_t predicted;
    in_valid         <= 1'b1;
    req_type         <= it.req_type;
    requested_state  <= it.requested_state;
    afe_protection   <= it.afe_protection;
    afe_switch_state <= it.afe_switch_state;
    pack_voltage_mv  <= it.pack_voltage_mv;
    do @(posedge clk); while (in_stall);
    predicted = predict_sequencer_result(it);
    results_due.push_back(checked ? typed_res : predicted);
    if (idling_allowed && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Registers change only once every outstanding result has come back.
  task automatic write_settings(input cfg_t c);
    logic [7:0] spare;
    spare = 8'($urandom);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    write_register(CFG_PRECHARGE_TIME, c.precharge_time_ms);
    write_register(CFG_RETRY_OFF_TIME, c.retry_off_time_ms);
    write_register(CFG_VOLTAGE_THRESH, c.voltage_threshold_mv);
    write_register(CFG_MAX_RETRIES, {spare, c.max_retries});
    cfg_we <= 1'b0;
    cfg_model = c;
  endtask

  // From any initialized state with a nonzero precharge time this lands in the precharge phase.
  task automatic enter_precharge();
    apply_item(make_item(REQ_SET, TGT_CHARGE, 1'b0, 2'd0, 16'd0), 1'b0, '0);
    apply_item(make_item(REQ_SET, TGT_OFF, 1'b0, 2'd0, 16'd0), 1'b0, '0);
    apply_item(make_item(REQ_SET, TGT_ON, 1'b0, 2'd0, 16'd0), 1'b0, '0);
  endtask

  // Mostly ticks while precharge is running and mostly valid requests otherwise,
  // with protection, invalid states, init and unused request types mixed in.
  function automatic item_t next_random_item();
    item_t       it;
    int unsigned roll;
    bit          busy;
    logic [15:0] thr;
    thr  = cfg_model.voltage_threshold_mv;
    busy = (phase_model == PH_PRE || phase_model == PH_RETRY_ON ||
            phase_model == PH_RETRY_OFF);
    it.req_type         = REQ_SET;
    it.requested_state  = 3'($urandom_range(0, 3));
    it.afe_protection   = 1'b0;
    it.afe_switch_state = 2'($urandom_range(0, 3));
    it.pack_voltage_mv  = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < (busy ? 80 : 30)) begin
      it.req_type = REQ_TICK;
      case ($urandom_range(0, 3))
        0: it.pack_voltage_mv = 16'($urandom);
        1: it.pack_voltage_mv = thr;
        2: it.pack_voltage_mv = thr - 16'd1;
        default: it.pack_voltage_mv = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
    end else if (roll < 86) begin
      it.req_type = REQ_SET;
    end else if (roll < 91) begin
      it.req_type = REQ_INIT;
    end else if (roll < 94) begin
      it.afe_protection  = 1'b1;
      it.requested_state = 3'($urandom_range(0, 7));
    end else if (roll < 97) begin
      it.requested_state = 3'($urandom_range(4, 7));
    end else begin
      it.req_type        = REQ_UNUSED;
      it.requested_state = 3'($urandom_range(0, 7));
      it.afe_protection  = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  initial begin : stimulus
    stim_row_t   directed_rows[$];
    cfg_t        settings;
    int unsigned count;
    int unsigned pre_ms;

    cfg_model   = settings_of(RST_PRECHARGE_TIME, RST_RETRY_OFF_TIME, RST_VOLTAGE_THRESH,
                              RST_MAX_RETRIES);
    tgt_model   = TGT_UNINIT;
    phase_model = PH_UNINIT;
    elapsed_ms  = 16'd0;
    retry_tally = 8'd0;
    pin_model   = 1'b0;

    // Before init: uninitialized, idle tick, invalid request, unused request type.
    directed_rows.push_back(checked_row(make_item(REQ_SET, TGT_ON, 1'b0, 2'd0, 16'd0),
                            result_of(RS_UNINIT, 1'b0, 2'd0, 1'b0, 1'b0, EV_OFF)));
    directed_rows.push_back(checked_row(make_item(REQ_TICK, TGT_OFF, 1'b0, 2'd0, 16'hFFFF),
                            result_of(RS_TICK, 1'b0, 2'd0, 1'b0, 1'b0, EV_OFF)));
    directed_rows.push_back(checked_row(make_item(REQ_SET, TGT_UNINIT, 1'b0, 2'd0, 16'd0),
                            result_of(RS_INVALID, 1'b0, 2'd0, 1'b0, 1'b0, EV_OFF)));
    directed_rows.push_back(checked_row(
                            make_item(REQ_UNUSED, TGT_RETRY_FAIL, 1'b1, 2'd3, 16'hFFFF),
                            result_of(RS_TICK, 1'b0, 2'd0, 1'b0, 1'b0, EV_OFF)));
    // Init loads the front-end state, which then equals the request.
    directed_rows.push_back(checked_row(
                            make_item(REQ_INIT, TGT_CHARGE, 1'b0, TGT_CHARGE[1:0], 16'd0),
                            result_of(RS_SUCCESS, 1'b0, 2'd0, 1'b0, 1'b0, EV_OFF)));
    directed_rows.push_back(checked_row(make_item(REQ_SET, TGT_OFF, 1'b0, 2'd0, 16'd0),
                            result_of(RS_SUCCESS, 1'b1, TGT_OFF[1:0], 1'b0, 1'b1, EV_OFF)));
    directed_rows.push_back(checked_row(make_item(REQ_SET, TGT_DISCHARGE, 1'b1, 2'd0, 16'd0),
                            result_of(RS_FORBIDDEN, 1'b0, 2'd0, 1'b0, 1'b0, EV_OFF)));
    // Precharge at reset settings: one failed check, a pause, then success at threshold.
    directed_rows.push_back(item_row(make_item(REQ_SET, TGT_DISCHARGE, 1'b0, 2'd0, 16'd0), 1));
    directed_rows.push_back(item_row(make_item(REQ_TICK, TGT_OFF, 1'b0, 2'd0, 16'd0), 49));
    directed_rows.push_back(item_row(make_item(REQ_TICK, TGT_OFF, 1'b0, 2'd0, 16'd29999), 1));
    directed_rows.push_back(item_row(make_item(REQ_TICK, TGT_OFF, 1'b0, 2'd0, 16'd0), 100));
    directed_rows.push_back(item_row(make_item(REQ_TICK, TGT_OFF, 1'b0, 2'd0, 16'd30000), 50));
    directed_rows.push_back(item_row(make_item(REQ_SET, TGT_DISCHARGE, 1'b0, 2'd0, 16'd0), 1));
    directed_rows.push_back(item_row(make_item(REQ_SET, TGT_CHARGE, 1'b0, 2'd0, 16'd0), 1));
    directed_rows.push_back(item_row(make_item(REQ_SET, TGT_OFF, 1'b0, 2'd0, 16'd0), 1));
    // No retries allowed: the first failed check latches the failure.
    directed_rows.push_back(settings_row(settings_of(16'd20, 16'd10, 16'hFFFF, 8'd0)));
    directed_rows.push_back(item_row(make_item(REQ_SET, TGT_ON, 1'b0, 2'd0, 16'd0), 1));
    directed_rows.push_back(item_row(make_item(REQ_TICK, TGT_OFF, 1'b0, 2'd0, 16'hFFFE), 2));
    directed_rows.push_back(item_row(make_item(REQ_TICK, TGT_OFF, 1'b0, 2'd0, 16'd0), 2));
    // Leaving the latched failure drives directly; protection from the on phase.
    directed_rows.push_back(item_row(make_item(REQ_SET, TGT_ON, 1'b0, 2'd0, 16'd0), 1));
    directed_rows.push_back(item_row(make_item(REQ_SET, TGT_UNINIT, 1'b1, 2'd3, 16'd0), 1));
    directed_rows.push_back(item_row(make_item(REQ_SET, TGT_DISCHARGE, 1'b0, 2'd0, 16'd0), 1));
    // Zero precharge time turns on without precharge.
    directed_rows.push_back(settings_row(settings_of(16'd0, 16'd0, 16'd0, 8'hFF)));
    directed_rows.push_back(item_row(make_item(REQ_SET, TGT_OFF, 1'b0, 2'd0, 16'd0), 1));
    directed_rows.push_back(item_row(make_item(REQ_SET, TGT_ON, 1'b0, 2'd0, 16'd0), 1));
    directed_rows.push_back(checked_row(make_item(REQ_INIT, TGT_FIRST_BAD, 1'b0, 2'd2, 16'd0),
                            result_of(RS_INVALID, 1'b0, 2'd0, 1'b0, 1'b0, EV_OFF)));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_settings) begin
        write_settings(directed_rows[k].settings);
      end else begin
        repeat (directed_rows[k].reps)
          apply_item(directed_rows[k].req, directed_rows[k].checked, directed_rows[k].res);
      end
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < 8; p++) begin
      pre_ms = $urandom_range(0, 6) * 10 + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 9) : 0);
      case (p)
        0: settings = settings_of(RST_PRECHARGE_TIME, RST_RETRY_OFF_TIME, RST_VOLTAGE_THRESH,
                                  RST_MAX_RETRIES);
        1: settings = settings_of(16'd0, 16'd0, 16'd0, 8'd0);
        2: settings = settings_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        3: settings = settings_of(16'd10, 16'd10, 16'hFFFF, 8'hFF);
        4: settings = settings_of(16'd20, 16'd20, 16'($urandom), 8'd254);
        default: settings = settings_of(16'(pre_ms), 16'($urandom_range(0, 40)),
                                        16'($urandom), 8'($urandom_range(0, 4)));
      endcase
      idling_allowed = (p != 7) && ($urandom_range(0, 3) != 0);
      write_settings(settings);
      count = 150;
      if (p == 2) begin
        // Longest precharge: the timer keeps running well short of its check.
        enter_precharge();
        repeat (200) apply_item(make_item(REQ_TICK, TGT_OFF, 1'b0, 2'd0, 16'd0), 1'b0, '0);
        count = 0;
      end else if (p == 3) begin
        // Endless failing checks push the retry count into saturation.
        enter_precharge();
        repeat (530) apply_item(make_item(REQ_TICK, TGT_OFF, 1'b0, 2'd0, 16'd0), 1'b0, '0);
      end
      repeat (count) apply_item(next_random_item(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[precharge_mosfet_sequencer_top] OK");
    end else begin
      $display("[precharge_mosfet_sequencer_top] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts and result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || !idling_allowed) begin
      out_stall      <= 1'b0;
      sink_hold_left <= 0;
    end else if (sink_hold_left != 0) begin
      sink_hold_left <= sink_hold_left - 1;
      out_stall      <= 1'b1;
    end else if ($urandom_range(0, 99) < 8) begin
      sink_hold_left <= $urandom_range(1, 10) - 1;
      out_stall      <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Each accepted result transaction is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("Result transaction arrived with nothing outstanding.");
        error_count++;
      end else begin
        want = results_due.pop_front();
        check_field("status", 16'(want.status), 16'(status));
        check_field("drive_write", 16'(want.drive_write), 16'(drive_write));
        check_field("drive_value", 16'(want.drive_value), 16'(drive_value));
        check_field("precharge_pin", 16'(want.precharge_pin), 16'(precharge_pin));
        check_field("event_valid", 16'(want.event_valid), 16'(event_valid));
        check_field("event_code", 16'(want.event_code), 16'(event_code));
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #25_000_000;
    $display("[precharge_mosfet_sequencer_top] ERROR");
    $finish;
  end

endmodule
